/* hdl/ddp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDP packetizer package
// Shared constants, byte positions and the command passed from the front end
// to the byte serialiser.
// ----------------------------------------------------------------------------
package ddp_pkg;

	localparam int LEDS_PER_PACKET = 480;
	localparam int MAX_LEDS        = 4096;

	localparam int CNT_W  = 13;   // width of the LED count register
	localparam int LEFT_W = 9;    // holds up to LEDS_PER_PACKET
	localparam int SEQ_W  = 4;

	localparam logic [7:0]       DDP_FLAGS = 8'h40;
	localparam logic [7:0]       DDP_PUSH  = 8'h01;
	localparam logic [7:0]       DDP_TYPE  = 8'h0B;
	localparam logic [7:0]       DDP_ID    = 8'h01;
	localparam logic [SEQ_W-1:0] SEQ_MAX   = 4'd15;
	localparam logic [SEQ_W-1:0] SEQ_FIRST = 4'd1;

	// Position of each byte within the thirteen bytes of a headed LED.
	localparam logic [3:0] BYTE_FLAGS = 4'd0;
	localparam logic [3:0] BYTE_SEQ   = 4'd1;
	localparam logic [3:0] BYTE_TYPE  = 4'd2;
	localparam logic [3:0] BYTE_ID    = 4'd3;
	localparam logic [3:0] BYTE_OFF3  = 4'd4;
	localparam logic [3:0] BYTE_OFF2  = 4'd5;
	localparam logic [3:0] BYTE_OFF1  = 4'd6;
	localparam logic [3:0] BYTE_OFF0  = 4'd7;
	localparam logic [3:0] BYTE_LEN1  = 4'd8;
	localparam logic [3:0] BYTE_LEN0  = 4'd9;
	localparam logic [3:0] BYTE_RED   = 4'd10;
	localparam logic [3:0] BYTE_GREEN = 4'd11;
	localparam logic [3:0] BYTE_BLUE  = 4'd12;

	typedef struct packed {
		logic              hdr;    // a header precedes this LED
		logic              push;   // header belongs to the frame's last packet
		logic [SEQ_W-1:0]  seq;
		logic [CNT_W-1:0]  pos;    // this LED's index; the packet's first when hdr
		logic [LEFT_W-1:0] npkt;   // LEDs in the packet when hdr is set
		logic [7:0]        red;
		logic [7:0]        green;
		logic [7:0]        blue;
		logic              eop;    // blue byte closes the packet
	} cmd_t;

endpackage

/* hdl/ddp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDP front end
// Holds the frame and packet bookkeeping, classifies each LED and issues one
// command per LED to the queue.
// ----------------------------------------------------------------------------
module ddp_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ddp_pkg::CNT_W-1:0]   cfg_count,
	input  logic                        take,
	input  logic [7:0]                  red,
	input  logic [7:0]                  green,
	input  logic [7:0]                  blue,
	output ddp_pkg::cmd_t               cmd
);
	import ddp_pkg::*;

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  pos_q;
	logic [LEFT_W-1:0] left_q;
	logic [SEQ_W-1:0]  seq_q;

	logic [CNT_W-1:0]  count_eff;
	logic              wrap;
	logic [CNT_W-1:0]  pos_e;
	logic [LEFT_W-1:0] left_e;
	logic              hdr;
	logic [CNT_W-1:0]  remaining;
	logic [LEFT_W-1:0] in_pkt;
	logic [LEFT_W-1:0] left_new;
	logic [CNT_W-1:0]  pos_new;
	logic              frame_end;
	logic              packet_end;

	// The register keeps the count already clamped to 1..MAX_LEDS.
	always_comb begin
		count_eff = cfg_count;
		if (cfg_count == '0) begin
			count_eff = CNT_W'(1);
		end else if (32'(cfg_count) > 32'(MAX_LEDS)) begin
			count_eff = CNT_W'(MAX_LEDS);
		end
	end

	always_comb begin
		wrap       = (pos_q >= count_q);
		pos_e      = wrap ? '0 : pos_q;
		left_e     = wrap ? '0 : left_q;
		hdr        = (left_e == '0);
		remaining  = count_q - pos_e;
		in_pkt     = (remaining < CNT_W'(LEDS_PER_PACKET)) ? remaining[LEFT_W-1:0]
			: LEFT_W'(LEDS_PER_PACKET);
		left_new   = (hdr ? in_pkt : left_e) - LEFT_W'(1);
		pos_new    = pos_e + CNT_W'(1);
		frame_end  = (pos_new >= count_q);
		packet_end = (left_new == '0) || frame_end;

		cmd.hdr   = hdr;
		cmd.push  = (remaining <= CNT_W'(LEDS_PER_PACKET));
		cmd.seq   = seq_q;
		cmd.pos   = pos_e;
		cmd.npkt  = in_pkt;
		cmd.red   = red;
		cmd.green = green;
		cmd.blue  = blue;
		cmd.eop   = packet_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(1);
			pos_q   <= '0;
			left_q  <= '0;
			seq_q   <= SEQ_FIRST;
		end else begin
			if (cfg_we) begin
				count_q <= count_eff;
			end
			if (take) begin
				pos_q  <= frame_end ? '0 : pos_new;
				left_q <= packet_end ? '0 : left_new;
				if (packet_end) begin
					seq_q <= (seq_q >= SEQ_MAX) ? SEQ_FIRST : seq_q + SEQ_W'(1);
				end
			end
		end
	end

endmodule

/* hdl/ddp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDP command queue
// Two-entry queue that decouples the front end from the byte serialiser.
// ----------------------------------------------------------------------------
module ddp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ddp_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          full,
	output logic          not_empty,
	output ddp_pkg::cmd_t head
);
	import ddp_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] fill_q;

	assign full      = (fill_q == 2'd2);
	assign not_empty = (fill_q != 2'd0);
	assign head      = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

/* hdl/ddp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDP byte serialiser
// Turns the command at the head of the queue into header and colour bytes,
// one byte per cycle while not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module ddp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  ddp_pkg::cmd_t head,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    data_byte,
	output logic          end_of_packet,
	output logic          end_of_run
);
	import ddp_pkg::*;

	logic [3:0]  idx_q;
	logic        out_valid_q;
	logic [7:0]  byte_q;
	logic        eop_q;
	logic        eor_q;

	logic        advance;
	logic [3:0]  cur;
	logic        last;
	logic [15:0] offset;
	logic [15:0] length;
	logic [7:0]  byte_d;

	assign advance = head_valid && (!out_valid_q || !out_stall);
	assign cur     = (idx_q == BYTE_FLAGS && !head.hdr) ? BYTE_RED : idx_q;
	assign last    = (cur == BYTE_BLUE);
	assign pop     = advance && last;
	assign offset  = {2'b00, head.pos, 1'b0} + {3'b000, head.pos};
	assign length  = {6'd0, head.npkt, 1'b0} + {7'd0, head.npkt};

	always_comb begin
		case (cur)
			BYTE_FLAGS: byte_d = head.push ? (DDP_FLAGS | DDP_PUSH) : DDP_FLAGS;
			BYTE_SEQ:   byte_d = {4'd0, head.seq};
			BYTE_TYPE:  byte_d = DDP_TYPE;
			BYTE_ID:    byte_d = DDP_ID;
			BYTE_OFF3:  byte_d = 8'd0;
			BYTE_OFF2:  byte_d = 8'd0;
			BYTE_OFF1:  byte_d = offset[15:8];
			BYTE_OFF0:  byte_d = offset[7:0];
			BYTE_LEN1:  byte_d = length[15:8];
			BYTE_LEN0:  byte_d = length[7:0];
			BYTE_RED:   byte_d = head.red;
			BYTE_GREEN: byte_d = head.green;
			BYTE_BLUE:  byte_d = head.blue;
			default:    byte_d = 8'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q <= byte_d;
			eop_q  <= last && head.eop;
			eor_q  <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= BYTE_FLAGS;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				idx_q       <= last ? BYTE_FLAGS : cur + 4'd1;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign data_byte     = byte_q;
	assign end_of_packet = eop_q;
	assign end_of_run    = eor_q;

endmodule

/* hdl/ddp_rgb_packetizer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDP RGB packetizer core
// Turns a stream of LED colours into a DDP byte stream with packet headers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, red, green, blue): one LED colour per
//   transfer. Output channel (out_valid / out_stall, data_byte, end_of_packet,
//   end_of_run): one byte per transfer; end_of_run marks the last byte that
//   an LED produces and end_of_packet the last byte of a DDP packet.
//   Configuration channel (cfg_valid / cfg_ready, led_count): sets the LEDs
//   per frame, clamped to 1..MAX_LEDS; write it only while the block is idle.
// Path and throughput:
//   The first byte of an LED passes through the command queue and the
//   output register. While out_stall is low, output runs at one byte per
//   cycle; an LED gives 3 bytes, or 13 when it opens a packet, and the
//   byte serialiser's single output port sets this rate. The two-entry queue
//   lets a further LED be taken while the current one is still being sent.
// Reset: clears the queue and output valid, sets the LED count to 1, the
//   frame position to 0 and the sequence number to 1.
// Stalling: when out_stall is high the output byte is held; once the queue is
//   full in_stall rises until the serialiser frees an entry.
// ----------------------------------------------------------------------------
module ddp_rgb_packetizer_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [ddp_pkg::CNT_W-1:0] led_count,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                red,
	input  logic [7:0]                green,
	input  logic [7:0]                blue,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [7:0]                data_byte,
	output logic                      end_of_packet,
	output logic                      end_of_run
);
	import ddp_pkg::*;

	cmd_t front_cmd;
	cmd_t head;
	logic take;
	logic full;
	logic not_empty;
	logic pop;

	// Configuration is always accepted; it lands in the front end's register.
	assign cfg_ready = 1'b1;

	// An LED transfer goes straight into the queue as a command.
	assign in_stall = full;
	assign take     = in_valid && !full;

	ddp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_count (led_count),
		.take      (take),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.cmd       (front_cmd)
	);

	ddp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_cmd  (front_cmd),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.head      (head)
	);

	// The serialiser releases a queue entry as it registers the blue byte.
	ddp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (not_empty),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.data_byte     (data_byte),
		.end_of_packet (end_of_packet),
		.end_of_run    (end_of_run)
	);

endmodule

/* tb/ddp_rgb_packetizer_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDP RGB packetizer core testbench
// Sends LED colours through the packetizer and checks every byte that comes
// out against a cycle-free model of the DDP stream. The model builds the
// headers, colour bytes and end markers, and tracks the frame position,
// packet fill and sequence number. Colours are offered in bursts with random
// gaps while the byte receiver stalls on a shifting pattern. One long
// receiver hold-off fills the block's queue so that its input stalls.
// ----------------------------------------------------------------------------
module ddp_rgb_packetizer_core_tb;

	import ddp_pkg::*;

	// The longest stretch with no transfer of any kind is the receiver's long
	// hold-off; anything far beyond it means the block has hung.
	localparam int HOLD_CYCLES  = 150;
	localparam int QUIET_LIMIT  = 1000;
	localparam int RANDOM_LEDS  = 90;
	localparam int REPORT_LIMIT = 20;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} colour_t;

	typedef struct {
		logic [7:0] value;
		logic       eop;
		logic       eor;
	} stream_byte_t;

	// Block ports. Every input has a known value from time zero.
	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CNT_W-1:0] led_count = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [7:0]       red = 8'h00;
	logic [7:0]       green = 8'h00;
	logic [7:0]       blue = 8'h00;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [7:0]       data_byte;
	logic             end_of_packet;
	logic             end_of_run;

	// Colours waiting to be offered, and the bytes the block still owes us.
	colour_t      colours_to_send[$];
	stream_byte_t stream_bytes[$];

	// Our own copy of the block's register and state, as it stands after reset.
	logic [CNT_W-1:0] frame_leds = CNT_W'(1);
	int               led_pos = 0;
	int               leds_owed = 0;
	logic [SEQ_W-1:0] seq_num = SEQ_FIRST;

	int mismatches = 0;

	// Sender burst shaping.
	int burst_left = 8;
	int gap_left = 0;

	// Receiver pattern and long hold-off.
	logic [31:0] rx_cycle = '0;
	int          leds_seen = 0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;

	int quiet_cycles = 0;

	ddp_rgb_packetizer_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.led_count     (led_count),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.data_byte     (data_byte),
		.end_of_packet (end_of_packet),
		.end_of_run    (end_of_run)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void owe_byte(input logic [7:0] value, input logic eop, input logic eor);
		stream_byte_t b;
		b.value = value;
		b.eop   = eop;
		b.eor   = eor;
		stream_bytes.push_back(b);
	endfunction

	// Works out the bytes that one accepted LED colour produces and moves the
	// frame, packet and sequence state on exactly as the block should.
	function automatic void pack_led(input colour_t c);
		int          frame_size;
		int          remaining;
		int          in_pkt;
		logic [31:0] offset;
		logic [15:0] length;
		logic        last_pkt;
		logic        frame_end;
		logic        packet_end;

		// A count of zero means one LED; anything above the maximum is clamped.
		frame_size = int'(frame_leds);
		if (frame_size == 0)
			frame_size = 1;
		if (frame_size > MAX_LEDS)
			frame_size = MAX_LEDS;

		// The count was lowered under our feet: drop the open packet silently
		// and start a fresh frame.
		if (led_pos >= frame_size) begin
			led_pos   = 0;
			leds_owed = 0;
		end

		if (leds_owed == 0) begin
			remaining = frame_size - led_pos;
			in_pkt    = (remaining < LEDS_PER_PACKET) ? remaining : LEDS_PER_PACKET;
			offset    = 32'(led_pos * 3);
			length    = 16'(in_pkt * 3);
			last_pkt  = (led_pos + in_pkt) >= frame_size;
			owe_byte(DDP_FLAGS | (last_pkt ? DDP_PUSH : 8'h00), 1'b0, 1'b0);
			owe_byte({4'h0, seq_num}, 1'b0, 1'b0);
			owe_byte(DDP_TYPE, 1'b0, 1'b0);
			owe_byte(DDP_ID, 1'b0, 1'b0);
			owe_byte(offset[31:24], 1'b0, 1'b0);
			owe_byte(offset[23:16], 1'b0, 1'b0);
			owe_byte(offset[15:8], 1'b0, 1'b0);
			owe_byte(offset[7:0], 1'b0, 1'b0);
			owe_byte(length[15:8], 1'b0, 1'b0);
			owe_byte(length[7:0], 1'b0, 1'b0);
			leds_owed = in_pkt;
		end

		leds_owed--;
		led_pos++;
		frame_end = led_pos >= frame_size;
		// A frame that ends early still closes its packet on the blue byte.
		packet_end = (leds_owed == 0) || frame_end;

		owe_byte(c.red, 1'b0, 1'b0);
		owe_byte(c.green, 1'b0, 1'b0);
		owe_byte(c.blue, packet_end, 1'b1);

		if (packet_end) begin
			leds_owed = 0;
			seq_num   = (seq_num >= SEQ_MAX) ? SEQ_FIRST : seq_num + SEQ_W'(1);
		end
		if (frame_end)
			led_pos = 0;
	endfunction

	function automatic logic [7:0] random_level();
		int p;
		p = $urandom_range(0, 9);
		if (p == 0)
			return 8'h00;
		if (p == 1)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	// Directed colours walk all-zero, all-one and the two checkerboards
	// through each field so that every bit toggles early on.
	task automatic queue_leds(input int n, input bit directed);
		logic [7:0] levels[4];
		colour_t    c;
		levels = '{8'h00, 8'hFF, 8'h55, 8'hAA};
		for (int i = 0; i < n; i++) begin
			if (directed) begin
				c.red   = levels[i % 4];
				c.green = levels[(i + 1) % 4];
				c.blue  = levels[(i + 2) % 4];
			end else begin
				c.red   = random_level();
				c.green = random_level();
				c.blue  = random_level();
			end
			colours_to_send.push_back(c);
		end
	endtask

	// The register is only touched once the block has nothing left to send.
	task automatic set_frame_leds(input logic [CNT_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		led_count <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid  <= 1'b0;
		frame_leds  = value;
	endtask

	// Every colour produces bytes, so once the expected stream is empty the
	// block is idle; a few cycles of margin cover the output register.
	task automatic wait_drained();
		while (colours_to_send.size() != 0 || stream_bytes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_leds(input int n, input bit directed);
		queue_leds(n, directed);
		wait_drained();
	endtask

	initial begin : stimulus
		int         sent;
		int         nleds;
		int         pick;
		logic [CNT_W-1:0] setting;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With the reset count of one, every LED is a complete frame with push.
		run_leds(2, 1'b1);

		// A count of zero must behave as a count of one.
		set_frame_leds(CNT_W'(0));
		run_leds(2, 1'b1);

		// Leave a ten-LED frame half done, then lower the count below the
		// current position: the open packet is dropped and a new frame opens.
		set_frame_leds(CNT_W'(10));
		run_leds(4, 1'b1);
		set_frame_leds(CNT_W'(2));
		run_leds(1, 1'b1);

		// Raise the count mid-packet: the short packet finishes first, then a
		// new packet with a non-zero offset covers the rest of the frame.
		set_frame_leds(CNT_W'(20));
		run_leds(3, 1'b1);

		// Lower it again so the frame ends while the packet still owes LEDs.
		set_frame_leds(CNT_W'(5));
		run_leds(2, 1'b1);

		// Largest legal frame: these LEDs carry on the packet left open by the five-LED frame.
		set_frame_leds(CNT_W'(MAX_LEDS));
		run_leds(3, 1'b0);

		// The widest register value clamps to the maximum, so the packet that
		// opens is full length and not pushed. This run is long enough
		// for the receiver's long hold-off to fill the block.
		set_frame_leds('1);
		run_leds(24, 1'b0);

		// Random phases, mostly short frames so that frame ends, count changes
		// mid-frame and sequence wraps all come round often.
		sent = 0;
		while (sent < RANDOM_LEDS) begin
			pick = $urandom_range(0, 99);
			if (pick < 55)
				setting = CNT_W'($urandom_range(1, 12));
			else if (pick < 80)
				setting = CNT_W'($urandom_range(13, 40));
			else if (pick < 90)
				setting = CNT_W'($urandom_range(470, 500));
			else if (pick < 95)
				setting = CNT_W'(0);
			else
				setting = CNT_W'($urandom_range(MAX_LEDS, (1 << CNT_W) - 1));
			// Now and then keep the current setting so frames run across phases.
			if ($urandom_range(0, 4) != 0)
				set_frame_leds(setting);
			nleds = $urandom_range(1, 20);
			run_leds(nleds, 1'b0);
			sent += nleds;
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0 && stream_bytes.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Colour driver. A stalled transfer holds both valid and payload; otherwise
	// the next colour is offered unless the current burst has run into a gap.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && in_stall)) begin
			if (in_valid)
				pack_led(colours_to_send.pop_front());
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (colours_to_send.size() > 0) begin
				in_valid <= 1'b1;
				red      <= colours_to_send[0].red;
				green    <= colours_to_send[0].green;
				blue     <= colours_to_send[0].blue;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					// Many bursts run straight into the next with no gap at all.
					gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Byte receiver. The stall pattern rotates with bits 7:6 of rx_cycle through free
	// running, light random stalls, a periodic stall and heavy random stalls.
	// Once twenty colours have gone in and plenty more are still waiting, it
	// holds off once for a long stretch.
	always @(posedge clk) begin
		if (in_valid && !in_stall)
			leds_seen++;
		rx_cycle <= rx_cycle + 32'd1;
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (!hold_done && leds_seen >= 20 && colours_to_send.size() >= 8) begin
			hold_done  = 1'b1;
			hold_left  = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			case (rx_cycle[7:6])
				2'd0: out_stall <= 1'b0;
				2'd1: out_stall <= ($urandom_range(0, 99) < 30);
				2'd2: out_stall <= (rx_cycle[2:0] == 3'd5);
				default: out_stall <= ($urandom_range(0, 99) < 70);
			endcase
		end
	end

	// Stream checker: each byte taken from the block is matched against the
	// oldest byte we are owed, field by field.
	always @(posedge clk) begin : check_stream
		stream_byte_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (stream_bytes.size() == 0) begin
				if (mismatches < REPORT_LIMIT)
					$display("%0t: unexpected byte: expected none, got %02h", $time, data_byte);
				mismatches++;
			end else begin
				want = stream_bytes.pop_front();
				if (data_byte !== want.value) begin
					if (mismatches < REPORT_LIMIT)
						$display("%0t: data_byte expected %02h, got %02h",
							$time, want.value, data_byte);
					mismatches++;
				end
				if (end_of_packet !== want.eop) begin
					if (mismatches < REPORT_LIMIT)
						$display("%0t: end_of_packet expected %0b, got %0b",
							$time, want.eop, end_of_packet);
					mismatches++;
				end
				if (end_of_run !== want.eor) begin
					if (mismatches < REPORT_LIMIT)
						$display("%0t: end_of_run expected %0b, got %0b",
							$time, want.eor, end_of_run);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: any transfer on any channel counts as progress.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
				$display("FAIL");
				$finish;
			end
		end
	end

endmodule
